### sv/wsat_pkg.sv
`timescale 1ns / 1ps

package wsat_pkg;

  localparam int unsigned REQ_W = 2;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned WSUM_W = 48;
  localparam int unsigned WCNT_W = 16;
  localparam int unsigned TSUM_W = 64;
  localparam int unsigned TCNT_W = 32;
  localparam int unsigned TICK_W = 16;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd500;
  localparam logic [WCNT_W-1:0] WCNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_res_t;

endpackage

### sv/wsat_div.sv
`timescale 1ns / 1ps

// Signed 64-bit by unsigned 32-bit divider, one quotient bit per cycle.
// Quotient truncates toward zero; only its low 32 bits come out.
module wsat_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wsat_pkg::TSUM_W-1:0]    dividend,
  input  logic [wsat_pkg::TCNT_W-1:0]    divisor,
  output wsat_pkg::div_res_t             res
);

  localparam int unsigned DW = wsat_pkg::TSUM_W;
  localparam int unsigned SW = wsat_pkg::TCNT_W;
  localparam int unsigned CW = $clog2(DW) + 1;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dsr_r, dsr_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   trial;
  logic          fits;
  logic [DW-1:0] mag;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign mag   = dividend[DW-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = fits ? SW'(trial - {1'b0, dsr_r}) : trial[SW-1:0];
      dvd_nxt = {dvd_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      dvd_nxt  = mag;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      neg_nxt  = dividend[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = neg_r ? (~dvd_r[SW-1:0] + 1'b1) : dvd_r[SW-1:0];

endmodule

### sv/windowed_stat_average_tracker.sv
`timescale 1ns / 1ps

// Windowed average tracker. A word is taken when start is high and busy is
// low. Push and query pass through the execute state; a query result appears
// on the out_ ports for one cycle with out_valid, and must be taken then.
// A tick that does not close the window returns to idle after the execute
// state. A closing tick walks all statistics in order, one per cycle where a
// statistic holds no samples; each one holding samples costs up to two passes
// of the shared divider. cfg_window_ticks may be written whenever busy is low.
module windowed_stat_average_tracker #(
  parameter int unsigned NUM_STATS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [wsat_pkg::REQ_W-1:0]          in_req_type,
  input  logic [wsat_pkg::IDX_W-1:0]          in_stat_index,
  input  logic signed [wsat_pkg::DATA_W-1:0]  in_sample_value,
  output logic                                out_valid,
  output logic signed [wsat_pkg::DATA_W-1:0]  out_window_mean,
  output logic signed [wsat_pkg::DATA_W-1:0]  out_lowest_mean,
  output logic signed [wsat_pkg::DATA_W-1:0]  out_highest_mean,
  output logic signed [wsat_pkg::DATA_W-1:0]  out_lifetime_mean,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsat_pkg::TICK_W-1:0]         cfg_window_ticks
);

  localparam int unsigned IW = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
  // one spare bit so NUM_STATS itself fits for the range compare
  localparam int unsigned EW = ((IW > wsat_pkg::IDX_W) ? IW : wsat_pkg::IDX_W) + 1;
  localparam int unsigned DW = wsat_pkg::DATA_W;
  localparam int unsigned SW = wsat_pkg::WSUM_W;
  localparam int unsigned CW = wsat_pkg::WCNT_W;
  localparam int unsigned TW = wsat_pkg::TSUM_W;
  localparam int unsigned NW = wsat_pkg::TCNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIVT = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;

  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_STATS - 1);

  logic signed [SW-1:0] wsum_r  [NUM_STATS];
  logic        [CW-1:0] wcnt_r  [NUM_STATS];
  logic signed [TW-1:0] tsum_r  [NUM_STATS];
  logic        [NW-1:0] tcnt_r  [NUM_STATS];
  logic signed [DW-1:0] last_r  [NUM_STATS];
  logic signed [DW-1:0] ovr_r   [NUM_STATS];
  logic signed [DW-1:0] min_r   [NUM_STATS];
  logic signed [DW-1:0] max_r   [NUM_STATS];

  logic [2:0]                   state_r;
  logic [wsat_pkg::TICK_W-1:0]  tick_r;
  logic [wsat_pkg::TICK_W-1:0]  wticks_r;
  logic [wsat_pkg::REQ_W-1:0]   req_r;
  logic [IW-1:0]                sel_r;
  logic                         inrange_r;
  logic signed [DW-1:0]         sample_r;
  logic [IW-1:0]                scan_r;

  logic                         accept;
  logic [EW-1:0]                idx_ext;
  logic [wsat_pkg::TICK_W-1:0]  tick_inc;
  logic [NW:0]                  tcnt_add;
  logic signed [TW-1:0]         tsum_add;
  logic                         div_start;
  logic [TW-1:0]                div_dvd;
  logic [NW-1:0]                div_dsr;
  wsat_pkg::div_res_t           div_res;

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign idx_ext   = EW'(in_stat_index);
  assign tick_inc  = tick_r + 1'b1;
  assign tcnt_add  = {1'b0, tcnt_r[scan_r]} + (NW + 1)'(wcnt_r[scan_r]);
  assign tsum_add  = tsum_r[scan_r] + TW'(wsum_r[scan_r]);

  // Divider launch: lifetime mean first when totals move, then window mean.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = TW'(wsum_r[scan_r]);
    div_dsr   = NW'(wcnt_r[scan_r]);
    if (state_r == S_SCAN && wcnt_r[scan_r] != '0) begin
      div_start = 1'b1;
      if (!tcnt_add[NW]) begin
        div_dvd = tsum_add;
        div_dsr = tcnt_add[NW-1:0];
      end
    end else if (state_r == S_DIVT && div_res.done) begin
      div_start = 1'b1;
    end
  end

  wsat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tick_r    <= '0;
      wticks_r  <= wsat_pkg::WINDOW_TICKS_RST;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_STATS; i++) begin
        wsum_r[i] <= '0;
        wcnt_r[i] <= '0;
        tsum_r[i] <= '0;
        tcnt_r[i] <= '0;
        last_r[i] <= '0;
        ovr_r[i]  <= '0;
        min_r[i]  <= {1'b0, {(DW-1){1'b1}}};
        max_r[i]  <= {1'b1, {(DW-1){1'b0}}};
      end
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        wticks_r <= cfg_window_ticks;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r     <= in_req_type;
            sel_r     <= idx_ext[IW-1:0];
            inrange_r <= idx_ext < EW'(NUM_STATS);
            sample_r  <= in_sample_value;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          priority if (req_r == wsat_pkg::REQ_PUSH) begin
            if (inrange_r && wcnt_r[sel_r] != wsat_pkg::WCNT_MAX) begin
              wsum_r[sel_r] <= wsum_r[sel_r] + SW'(sample_r);
              wcnt_r[sel_r] <= wcnt_r[sel_r] + 1'b1;
            end
          end else if (req_r == wsat_pkg::REQ_TICK) begin
            if (tick_inc >= wticks_r) begin
              tick_r  <= '0;
              scan_r  <= '0;
              state_r <= S_SCAN;
            end else begin
              tick_r <= tick_inc;
            end
          end else if (req_r == wsat_pkg::REQ_QUERY) begin
            out_valid <= 1'b1;
            if (!inrange_r) begin
              out_window_mean   <= '0;
              out_lowest_mean   <= '0;
              out_highest_mean  <= '0;
              out_lifetime_mean <= '0;
            end else begin
              out_window_mean   <= last_r[sel_r];
              out_lowest_mean   <= (tcnt_r[sel_r] != '0) ? min_r[sel_r] : '0;
              out_highest_mean  <= (tcnt_r[sel_r] != '0) ? max_r[sel_r] : '0;
              out_lifetime_mean <= ovr_r[sel_r];
            end
          end else begin
            // drop the unused request code
          end
        end
        S_SCAN: begin
          if (wcnt_r[scan_r] != '0) begin
            if (!tcnt_add[NW]) begin
              tsum_r[scan_r] <= tsum_add;
              tcnt_r[scan_r] <= tcnt_add[NW-1:0];
              state_r        <= S_DIVT;
            end else begin
              state_r <= S_DIVW;
            end
          end else if (scan_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_DIVT: begin
          if (div_res.done) begin
            ovr_r[scan_r] <= div_res.quo;
            state_r       <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_res.done) begin
            last_r[scan_r] <= div_res.quo;
            wsum_r[scan_r] <= '0;
            wcnt_r[scan_r] <= '0;
            if ($signed(div_res.quo) > max_r[scan_r]) max_r[scan_r] <= div_res.quo;
            if ($signed(div_res.quo) < min_r[scan_r]) min_r[scan_r] <= div_res.quo;
            if (scan_r == LAST_IDX) begin
              state_r <= S_IDLE;
            end else begin
              scan_r  <= scan_r + 1'b1;
              state_r <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_EXEC)
    else $error("result strobe without an executed request");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DIVW) |-> scan_r <= LAST_IDX)
    else $error("scan index past last statistic");

  a_div_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_res.done && state_r != S_DIVT) |-> state_r == S_DIVW)
    else $error("divider finished outside a wait state");

endmodule
